// File: hdl/mbsr_pkg.sv
// shared types, constants and the raster op function for the bitmap span engine
// no dependencies; every other file refers to it by scoped names
package mbsr_pkg;

    // bitmap geometry limits
    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int BPL_MAX     = (MAX_WIDTH + 7) / 8;
    localparam int STORE_BYTES = BPL_MAX * MAX_HEIGHT;

    // derived widths
    localparam int AW        = $clog2(STORE_BYTES);
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int QW        = CW - 3;
    localparam int RW        = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CFG_W     = 10;
    localparam int BW        = CFG_W - 2;
    localparam int CFG_IDX_W = 2;
    localparam int XW        = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] WIDTH_RST  = 10'd512;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 10'd512;

    typedef enum logic [1:0] {
        CMD_PLOT = 2'd0,
        CMD_SPAN = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ROP_CLEAR  = 2'd0,
        ROP_SET    = 2'd1,
        ROP_INVERT = 2'd2,
        ROP_KEEP   = 2'd3
    } t_rop;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [15:0] row;
        logic signed [15:0] x_start;
        logic signed [15:0] x_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped_out;
    } t_out_item;

    // effective geometry and op seen by the sequencer
    typedef struct packed {
        t_rop             rop;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } t_cfg;

    // one memory access per cycle from the sequencer
    typedef struct packed {
        logic          rd_en;
        logic          wb;
        logic          clr;
        logic [AW-1:0] addr;
        logic [7:0]    mask;
    } t_mem_req;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_seq_stat;

    // apply the raster op to one byte under a pixel mask
    function automatic logic [7:0] f_rop(t_rop op, logic [7:0] b, logic [7:0] m);
        logic [7:0] r;
        begin
            unique case (op)
                ROP_CLEAR:  r = b & ~m;
                ROP_SET:    r = b | m;
                ROP_INVERT: r = b ^ m;
                ROP_KEEP:   r = b;
            endcase
            return r;
        end
    endfunction

endpackage

// File: hdl/mbsr_store.sv
// bitmap byte store with a registered read port and a read-modify-write stage
// depends on mbsr_pkg for the request type, widths and the raster op
module mbsr_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbsr_pkg::t_mem_req  i_req,
    input  mbsr_pkg::t_rop      i_rop,
    output logic [7:0]          o_rdata
);

    logic [7:0]               r_mem [mbsr_pkg::STORE_BYTES];
    logic [7:0]               r_rdata;
    logic                     r_wr_vld;
    logic [mbsr_pkg::AW-1:0]  r_wr_addr;
    logic [7:0]               r_wr_mask;
    logic [7:0]               wr_data;

    // modified byte, from the data read in the previous cycle
    assign wr_data = mbsr_pkg::f_rop(i_rop, r_rdata, r_wr_mask);
    assign o_rdata = r_rdata;

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    // write port: clearing sweep or write-back of the byte read last cycle
    always_ff @(posedge i_clk) begin
        if (i_req.clr) begin
            r_mem[i_req.addr] <= 8'h00;
        end else if (r_wr_vld) begin
            r_mem[r_wr_addr] <= wr_data;
        end
    end

    // write-back stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld <= 1'b0;
        end else begin
            r_wr_vld <= i_req.rd_en & i_req.wb;
        end
    end

    // write-back stage payload
    always_ff @(posedge i_clk) begin
        r_wr_addr <= i_req.addr;
        r_wr_mask <= i_req.mask;
    end

endmodule

// File: hdl/mbsr_seq.sv
// command sequencer: clipping, byte address setup and the per-byte read stream
// depends on mbsr_pkg; drives mbsr_store through a t_mem_req struct
module mbsr_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mbsr_pkg::t_in_item  i_in_req,
    input  mbsr_pkg::t_cfg      i_cfg,
    output mbsr_pkg::t_mem_req  o_mem,
    input  logic [7:0]          i_rdata,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output mbsr_pkg::t_out_item o_res,
    output mbsr_pkg::t_seq_stat o_stat
);

    mbsr_pkg::t_state           r_state;
    mbsr_pkg::t_state           n_state;
    logic [mbsr_pkg::AW-1:0]    r_clr_addr;
    mbsr_pkg::t_in_item         r_item;
    logic [mbsr_pkg::AW-1:0]    r_base;
    logic [mbsr_pkg::QW-1:0]    r_q;
    logic [mbsr_pkg::QW-1:0]    r_qa;
    logic [mbsr_pkg::QW-1:0]    r_qb;
    logic [7:0]                 r_head;
    logic [7:0]                 r_tail;
    logic                       r_clip;
    logic [7:0]                 r_data;

    logic signed [mbsr_pkg::XW-1:0] row_e;
    logic signed [mbsr_pkg::XW-1:0] x1_e;
    logic signed [mbsr_pkg::XW-1:0] x2_e;
    logic signed [mbsr_pkg::XW-1:0] w_e;
    logic signed [mbsr_pkg::XW-1:0] h_e;
    logic signed [mbsr_pkg::XW-1:0] x1_c;
    logic signed [mbsr_pkg::XW-1:0] x2_c;
    logic signed [mbsr_pkg::XW-1:0] lo_e;
    logic signed [mbsr_pkg::XW-1:0] hi_e;
    logic                           row_ok;
    logic                           pt_clip;
    logic                           sp_clip;
    logic                           clip;
    logic [mbsr_pkg::CW-1:0]        lo_col;
    logic [mbsr_pkg::CW-1:0]        hi_col;
    logic [mbsr_pkg::BW-1:0]        bpl;
    logic [mbsr_pkg::CFG_W:0]       w_round;
    logic [mbsr_pkg::RW+mbsr_pkg::BW-1:0] prod;
    logic [7:0]                     byte_mask;
    logic                           run_last;
    logic                           clr_last;
    logic                           in_acc;

    // coordinates widened to signed 17 bits for clipping
    assign row_e = {r_item.row[15], r_item.row};
    assign x1_e  = {r_item.x_start[15], r_item.x_start};
    assign x2_e  = {r_item.x_end[15], r_item.x_end};
    assign w_e   = {{(mbsr_pkg::XW - mbsr_pkg::CFG_W){1'b0}}, i_cfg.width};
    assign h_e   = {{(mbsr_pkg::XW - mbsr_pkg::CFG_W){1'b0}}, i_cfg.height};

    // clip tests for a single pixel and for a span
    assign row_ok  = !row_e[mbsr_pkg::XW-1] && (row_e < h_e);
    assign pt_clip = !row_ok || x1_e[mbsr_pkg::XW-1] || (x1_e >= w_e);
    assign x1_c    = x1_e[mbsr_pkg::XW-1] ? '0 : x1_e;
    assign x2_c    = (x2_e >= w_e) ? (w_e - 17'sd1) : x2_e;
    assign sp_clip = !row_ok || (x2_c < x1_c);

    always_comb begin
        unique case (r_item.cmd)
            mbsr_pkg::CMD_PLOT, mbsr_pkg::CMD_READ: clip = pt_clip;
            mbsr_pkg::CMD_SPAN:                     clip = sp_clip;
            mbsr_pkg::CMD_NONE:                     clip = 1'b0;
        endcase
    end

    // first and last column; a plot or read is a one-pixel span
    assign lo_e   = (r_item.cmd == mbsr_pkg::CMD_SPAN) ? x1_c : x1_e;
    assign hi_e   = (r_item.cmd == mbsr_pkg::CMD_SPAN) ? x2_c : x1_e;
    assign lo_col = lo_e[mbsr_pkg::CW-1:0];
    assign hi_col = hi_e[mbsr_pkg::CW-1:0];

    // row base address: row times bytes per line
    assign w_round = {1'b0, i_cfg.width} + 11'd7;
    assign bpl     = w_round[mbsr_pkg::CFG_W:3];
    assign prod    = r_item.row[mbsr_pkg::RW-1:0] * bpl;

    // byte mask for the current byte of the span
    always_comb begin
        byte_mask = 8'hff;
        if (r_q == r_qa) begin
            byte_mask = byte_mask & r_head;
        end
        if (r_q == r_qb) begin
            byte_mask = byte_mask & r_tail;
        end
    end

    assign run_last = (r_q == r_qb);
    assign clr_last = (r_clr_addr == mbsr_pkg::AW'(mbsr_pkg::STORE_BYTES - 1));
    assign in_acc   = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbsr_pkg::ST_CLEAR: if (clr_last) n_state = mbsr_pkg::ST_IDLE;
            mbsr_pkg::ST_IDLE:  if (i_in_valid) n_state = mbsr_pkg::ST_SETUP;
            mbsr_pkg::ST_SETUP: begin
                if (clip || r_item.cmd == mbsr_pkg::CMD_NONE) begin
                    n_state = mbsr_pkg::ST_DONE;
                end else begin
                    n_state = mbsr_pkg::ST_RUN;
                end
            end
            mbsr_pkg::ST_RUN:   if (run_last) n_state = mbsr_pkg::ST_DRAIN;
            mbsr_pkg::ST_DRAIN: n_state = mbsr_pkg::ST_DONE;
            mbsr_pkg::ST_DONE:  if (i_res_ready) n_state = mbsr_pkg::ST_IDLE;
            default:            n_state = mbsr_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall      = 1'b1;
        o_res_valid     = 1'b0;
        o_mem.rd_en     = 1'b0;
        o_mem.wb        = 1'b0;
        o_mem.clr       = 1'b0;
        o_mem.addr      = r_base + mbsr_pkg::AW'(r_q);
        o_mem.mask      = byte_mask;
        o_stat.clearing = 1'b0;
        o_stat.busy     = 1'b1;
        unique case (r_state)
            mbsr_pkg::ST_CLEAR: begin
                o_mem.clr       = 1'b1;
                o_mem.addr      = r_clr_addr;
                o_stat.clearing = 1'b1;
            end
            mbsr_pkg::ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_stat.busy = 1'b0;
            end
            mbsr_pkg::ST_RUN: begin
                o_mem.rd_en = 1'b1;
                o_mem.wb    = (r_item.cmd != mbsr_pkg::CMD_READ);
            end
            mbsr_pkg::ST_DONE: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_res.read_data   = r_data;
    assign o_res.clipped_out = r_clip;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mbsr_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == mbsr_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // request capture, span setup and byte stepping
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_req;
        end
        if (r_state == mbsr_pkg::ST_SETUP) begin
            r_base <= mbsr_pkg::AW'(prod);
            r_q    <= lo_col[mbsr_pkg::CW-1:3];
            r_qa   <= lo_col[mbsr_pkg::CW-1:3];
            r_qb   <= hi_col[mbsr_pkg::CW-1:3];
            r_head <= 8'hff >> lo_col[2:0];
            r_tail <= 8'hff << (3'd7 - hi_col[2:0]);
            r_clip <= clip;
            r_data <= 8'h00;
        end
        if (r_state == mbsr_pkg::ST_RUN && !run_last) begin
            r_q <= r_q + 1'b1;
        end
        if (r_state == mbsr_pkg::ST_DRAIN && r_item.cmd == mbsr_pkg::CMD_READ) begin
            r_data <= i_rdata;
        end
    end

endmodule

// File: hdl/mono_bitmap_span_raster_op_core.sv
// top level of the bitmap span engine: config registers, result register, checks
// depends on mbsr_pkg, mbsr_seq and mbsr_store
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  input    | in        | i_in_valid/o_in_stall   | i_in_req   (cmd, row, x_start, x_end)
//  result   | out       | o_out_valid/i_out_stall | o_out_res  (read_data, clipped_out)
//  config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// a span touching n bytes does one byte read-modify-write per cycle on the single
// store read port, plus the setup, drain, result and accept steps; plot and read are a
// one-byte span, and a clipped request skips the run and drain steps.
// after reset the store is cleared one byte per cycle, all STORE_BYTES bytes,
// with o_in_stall high; config writes are taken at any time.
// a finished result waits in the output register while the next request is taken.
module mono_bitmap_span_raster_op_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mbsr_pkg::t_in_item                i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mbsr_pkg::t_out_item               o_out_res,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbsr_pkg::CFG_W-1:0]        i_cfg_data
);

    mbsr_pkg::t_rop             r_rop;
    logic [mbsr_pkg::CFG_W-1:0] r_width;
    logic [mbsr_pkg::CFG_W-1:0] r_height;
    logic                       r_out_valid;
    mbsr_pkg::t_out_item        r_out;
    mbsr_pkg::t_cfg             cfg;
    mbsr_pkg::t_mem_req         mem_req;
    mbsr_pkg::t_seq_stat        stat;
    mbsr_pkg::t_out_item        res;
    logic [7:0]                 rdata;
    logic                       res_valid;
    logic                       res_ready;
    logic                       res_load;
    logic                       in_acc;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rop    <= mbsr_pkg::ROP_SET;
            r_width  <= mbsr_pkg::WIDTH_RST;
            r_height <= mbsr_pkg::HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mbsr_pkg::CFG_IDX_ROP:    r_rop    <= mbsr_pkg::t_rop'(i_cfg_data[1:0]);
                mbsr_pkg::CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                mbsr_pkg::CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // oversized geometry is limited to the store size
    assign cfg.rop    = r_rop;
    assign cfg.width  = (int'(r_width) > mbsr_pkg::MAX_WIDTH) ?
                        mbsr_pkg::CFG_W'(mbsr_pkg::MAX_WIDTH) : r_width;
    assign cfg.height = (int'(r_height) > mbsr_pkg::MAX_HEIGHT) ?
                        mbsr_pkg::CFG_W'(mbsr_pkg::MAX_HEIGHT) : r_height;

    mbsr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .i_cfg       (cfg),
        .o_mem       (mem_req),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_stat      (stat)
    );

    mbsr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .i_rop   (r_rop),
        .o_rdata (rdata)
    );

    // output register
    assign res_ready = !r_out_valid || !i_out_stall;
    assign res_load  = res_valid && res_ready;
    assign in_acc    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // no request is taken while the store is being cleared
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> o_in_stall)
        else $error("request accepted during store clear");

    // one request at a time: the sequencer is busy right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> stat.busy && o_in_stall)
        else $error("second request taken while one is in flight");

    // a clipped result never carries read data
    a_clip_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res.clipped_out |-> res.read_data == 8'h00)
        else $error("clipped result with nonzero data");

    // a finished result that cannot be loaded is held by the sequencer
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result lost while output register full");

endmodule
